// ===== sv/mfr_pkg.sv =====
package mfr_pkg;

    // Frame layout
    localparam int unsigned PAYLOAD_LEN = 21;
    localparam int unsigned INDEX_W     = 5;
    localparam logic [7:0]  FRAME_MARK  = 8'hA5;

    // Receiver modes
    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_PAYLOAD = 2'd1,
        MODE_CHECK   = 2'd2,
        MODE_SKIP    = 2'd3
    } parse_mode_t;

    // Command markers that are followed by one confirm byte
    function automatic logic is_command_marker(input logic [7:0] b);
        logic hit;
        hit = 1'b0;
        unique case (b)
            8'hCA, 8'hBE, 8'hBD, 8'hBB, 8'hBA,
            8'hBF, 8'hB0, 8'hB2, 8'hB6, 8'hB7,
            8'hB4, 8'hC0, 8'hE3, 8'hE5, 8'hE6: hit = 1'b1;
            default:                           hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

// ===== sv/marker_frame_receiver_core.sv =====
// A result becomes valid in the cycle after the transfer of the checksum byte.
// Throughput: one received byte per cycle; the parser state updates in one pass.
// Input stalls only on a checksum byte while a previous result waits at the output.
// Reset (rst_n low, asynchronous) returns the parser to idle, clears the running
// sum, byte index and frame counter, and empties the output register.
module marker_frame_receiver_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] pmt_current,
    output logic signed [15:0] amp_one,
    output logic signed [15:0] amp_two,
    output logic signed [15:0] amp_three,
    output logic signed [15:0] battery_level,
    output logic signed [15:0] sampler_state,
    output logic signed [15:0] temperature_value,
    output logic signed [15:0] battery_current,
    output logic [7:0]         pmt_voltage,
    output logic [15:0]        frame_number
);

    localparam int unsigned LEN = mfr_pkg::PAYLOAD_LEN;
    localparam int unsigned IW  = mfr_pkg::INDEX_W;

    mfr_pkg::parse_mode_t mode_reg, mode_next;
    logic [IW-1:0]        index_reg, index_next;
    logic [7:0]           sum_reg, sum_next;
    logic [15:0]          count_reg, count_next;
    logic [7:0]           payload_reg [LEN];
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           res_reg [LEN];
    logic [15:0]          res_count_reg;

    logic in_xfer;
    logic out_xfer;
    logic shift_en;
    logic frame_good;

    // Stall input only when a checksum byte could overwrite a pending result
    assign in_ready = !(out_valid_reg && !out_ready && (mode_reg == mfr_pkg::MODE_CHECK));
    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid_reg && out_ready;

    // Parser next state
    always_comb
    begin
        mode_next  = mode_reg;
        index_next = index_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        shift_en   = 1'b0;
        frame_good = 1'b0;
        if (in_xfer)
        begin
            unique case (mode_reg)
                mfr_pkg::MODE_IDLE:
                begin
                    if (rx_byte == mfr_pkg::FRAME_MARK)
                    begin
                        mode_next  = mfr_pkg::MODE_PAYLOAD;
                        index_next = '0;
                        sum_next   = '0;
                    end
                    else if (mfr_pkg::is_command_marker(rx_byte))
                    begin
                        mode_next = mfr_pkg::MODE_SKIP;
                    end
                end
                mfr_pkg::MODE_PAYLOAD:
                begin
                    shift_en   = 1'b1;
                    sum_next   = sum_reg + rx_byte;
                    index_next = index_reg + IW'(1);
                    if (index_reg == IW'(LEN - 1))
                    begin
                        mode_next = mfr_pkg::MODE_CHECK;
                    end
                end
                mfr_pkg::MODE_CHECK:
                begin
                    mode_next  = mfr_pkg::MODE_IDLE;
                    index_next = '0;
                    if (rx_byte == sum_reg)
                    begin
                        frame_good = 1'b1;
                        count_next = count_reg + 16'd1;
                    end
                end
                mfr_pkg::MODE_SKIP:
                begin
                    mode_next = mfr_pkg::MODE_IDLE;
                end
                default:
                begin
                    mode_next = mfr_pkg::MODE_IDLE;
                end
            endcase
        end
    end

    // Output valid: load on a good frame, drop on a transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (frame_good)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= mfr_pkg::MODE_IDLE;
            index_reg     <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            index_reg     <= index_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload line: advance one byte per payload transfer, oldest at entry 0
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int i = 0; i < LEN - 1; i++)
            begin
                payload_reg[i] <= payload_reg[i+1];
            end
            payload_reg[LEN-1] <= rx_byte;
        end
    end

    // Result register: hold until taken
    always_ff @(posedge clk)
    begin
        if (frame_good)
        begin
            res_reg       <= payload_reg;
            res_count_reg <= count_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign pmt_current       = signed'({res_reg[1],  res_reg[0]});
    assign amp_one           = signed'({res_reg[3],  res_reg[2]});
    assign amp_two           = signed'({res_reg[5],  res_reg[4]});
    assign amp_three         = signed'({res_reg[7],  res_reg[6]});
    assign battery_level     = signed'({res_reg[9],  res_reg[8]});
    assign sampler_state     = signed'({res_reg[11], res_reg[10]});
    assign temperature_value = signed'({res_reg[13], res_reg[12]});
    assign battery_current   = signed'({res_reg[15], res_reg[14]});
    assign pmt_voltage       = res_reg[LEN-1];
    assign frame_number      = res_count_reg;

    // A stalled result blocks a checksum byte
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && mode_reg == mfr_pkg::MODE_CHECK) |-> !in_ready)
        else $error("checksum byte accepted while result pending");

    // Checksum byte always returns the parser to idle
    a_check_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && mode_reg == mfr_pkg::MODE_CHECK) |=> (mode_reg == mfr_pkg::MODE_IDLE))
        else $error("parser did not return to idle after checksum");

    // Good frame presents a result and advances the counter
    a_good_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && mode_reg == mfr_pkg::MODE_CHECK && rx_byte == sum_reg)
        |=> (out_valid_reg && count_reg == $past(count_reg) + 16'd1
             && res_count_reg == $past(count_reg)))
        else $error("good frame not reported");

    // Counter moves only with a good frame
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_xfer && mode_reg == mfr_pkg::MODE_CHECK) |=> $stable(count_reg))
        else $error("frame counter changed without a good frame");

    // Index stays inside the payload
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == mfr_pkg::MODE_PAYLOAD) |-> (index_reg < IW'(LEN)))
        else $error("payload index out of range");

endmodule
